/* hw/rtl/assert_macros.svh */
// Assertion macros for the RTL. They use the clock clk and the
// active-low reset rst_n of the module that includes this file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, expr)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* hw/rtl/i2cseq_pkg.sv */
package i2cseq_pkg;

  localparam int unsigned MaxTxnsDefault   = 4;
  localparam int unsigned ByteDepthDefault = 64;

  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 40;

  typedef enum logic [2:0] {
    OP_LOAD_TXN   = 3'd0,
    OP_LOAD_BYTE  = 3'd1,
    OP_START      = 3'd2,
    OP_START_SENT = 3'd3,
    OP_ADDR_ACKED = 3'd4,
    OP_BYTE_DONE  = 3'd5,
    OP_ERROR      = 3'd6
  } opcode_t;

  typedef struct packed {
    logic [6:0] addr;
    logic       rd;
    logic [6:0] len;
  } txn_t;

  typedef struct packed {
    logic       fault;
    logic       finished;
    logic [5:0] rx_index;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic [7:0] tx_byte;
    logic       send_data;
    logic [7:0] addr_byte;
    logic       send_addr;
    logic       ack_enable;
    logic       gen_stop;
    logic       gen_start;
  } result_t;

endpackage

/* hw/rtl/i2cseq_ram.sv */
module i2cseq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/i2c_master_transaction_sequencer.sv */
// I2C master transaction sequencer. Each request on the input stream (the
// operation code in in_tuser) yields exactly one result on the output stream.
// A request passes through an input register and a result register, so a
// new request is taken on every clock while the output is not stalled. The
// byte store is a RAM with one registered read port whose address follows
// the byte cursor, so the next byte to transmit is always ready; it needs no
// clearing after reset. The result of the request that completes a transfer
// carries out_tlast.
`include "assert_macros.svh"

module i2c_master_transaction_sequencer
  import i2cseq_pkg::*;
#(
  parameter int unsigned MAX_TXNS   = MaxTxnsDefault,
  parameter int unsigned BYTE_DEPTH = ByteDepthDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // slave_address[6:0], is_read[7], byte_count[14:8], data_byte[22:15]
  input  logic [InDataW-1:0]  in_tdata,
  // opcode[2:0]
  input  logic [2:0]          in_tuser,
  output logic                out_tvalid,
  input  logic                out_tready,
  // gen_start[0], gen_stop[1], ack_enable[2], send_addr[3], addr_byte[11:4],
  // send_data[12], tx_byte[20:13], rx_valid[21], rx_byte[29:22],
  // rx_index[35:30], fault[36]
  output logic [OutDataW-1:0] out_tdata,
  output logic                out_tlast
);

  localparam int unsigned TLW = $clog2(MAX_TXNS + 1);
  localparam int unsigned TIW = (MAX_TXNS > 1) ? $clog2(MAX_TXNS) : 1;
  localparam int unsigned CW  = $clog2(BYTE_DEPTH + 1);
  localparam int unsigned AW  = $clog2(BYTE_DEPTH);
  localparam int unsigned SW  = (CW > 7) ? CW + 1 : 8;

  typedef enum logic [3:0] {
    PH_STOPPED,
    PH_FAULTED,
    PH_STARTING,
    PH_R_ADDR,
    PH_R_PRE_ONE,
    PH_R_PRE_FIRST,
    PH_R_PRE_MIDDLE,
    PH_R_PRE_LAST,
    PH_W_ADDR,
    PH_W_MIDDLE,
    PH_W_LAST
  } phase_t;

  logic          s1_v_r;
  opcode_t       s1_op_r;
  logic [6:0]    s1_addr_r;
  logic          s1_rd_r;
  logic [6:0]    s1_len_r;
  logic [7:0]    s1_data_r;

  logic          out_v_r;
  result_t       res_r;
  result_t       res;
  logic          res_cmd;

  phase_t        phase_r, phase_nxt;
  txn_t          tt_r [MAX_TXNS];
  logic          tt_we;
  logic [TLW-1:0] txn_loaded_r, txn_loaded_nxt;
  logic [TIW-1:0] txn_cur_r, txn_cur_nxt;
  logic [TIW-1:0] tix;
  txn_t          tt_sel;
  logic [CW-1:0] byte_loaded_r, byte_loaded_nxt;
  logic [CW-1:0] cursor_r, cursor_nxt;
  logic [CW-1:0] end_r, end_nxt;
  logic          ack_r, ack_nxt;

  logic [CW-1:0] rem;
  logic          is_last;
  logic          do_enter;
  logic [SW-1:0] end_sum;
  logic          adv;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  assign adv       = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || adv;

  assign rem     = (end_r > cursor_r) ? (end_r - cursor_r) : '0;
  assign is_last = (TLW'(txn_cur_r) + TLW'(1)) >= txn_loaded_r;

  always_comb begin
    if (s1_op_r == OP_START) begin
      tix = '0;
    end else if (s1_op_r == OP_START_SENT) begin
      tix = txn_cur_r;
    end else begin
      tix = txn_cur_r + TIW'(1);
    end
  end

  assign tt_sel = tt_r[tix];

  always_comb begin
    phase_nxt       = phase_r;
    txn_loaded_nxt  = txn_loaded_r;
    txn_cur_nxt     = txn_cur_r;
    byte_loaded_nxt = byte_loaded_r;
    cursor_nxt      = cursor_r;
    end_nxt         = end_r;
    ack_nxt         = ack_r;
    tt_we           = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = byte_loaded_r[AW-1:0];
    ram_wdata       = s1_data_r;
    do_enter        = 1'b0;
    end_sum         = '0;
    res             = '0;

    if (adv && phase_r != PH_FAULTED) begin
      unique case (s1_op_r)
        OP_LOAD_TXN: begin
          if (phase_r == PH_STOPPED && txn_loaded_r < TLW'(MAX_TXNS)) begin
            tt_we          = 1'b1;
            txn_loaded_nxt = txn_loaded_r + TLW'(1);
          end
        end
        OP_LOAD_BYTE: begin
          if (phase_r == PH_STOPPED && byte_loaded_r < CW'(BYTE_DEPTH)) begin
            ram_we          = 1'b1;
            byte_loaded_nxt = byte_loaded_r + CW'(1);
          end
        end
        OP_START: begin
          if (phase_r == PH_STOPPED && txn_loaded_r != '0) begin
            txn_cur_nxt = '0;
            cursor_nxt  = '0;
            do_enter    = 1'b1;
          end else begin
            phase_nxt = PH_FAULTED;
          end
        end
        OP_START_SENT: begin
          if (phase_r == PH_STARTING) begin
            res.send_addr = 1'b1;
            res.addr_byte = {tt_sel.addr, tt_sel.rd};
            phase_nxt     = tt_sel.rd ? PH_R_ADDR : PH_W_ADDR;
          end else begin
            phase_nxt = PH_FAULTED;
          end
        end
        OP_ADDR_ACKED: begin
          if (phase_r == PH_R_ADDR) begin
            if (rem == CW'(1)) begin
              phase_nxt     = PH_R_PRE_ONE;
              ack_nxt       = 1'b0;
              res.gen_stop  = is_last;
              res.gen_start = !is_last;
            end else if (rem >= CW'(2)) begin
              phase_nxt = PH_R_PRE_FIRST;
              ack_nxt   = 1'b1;
            end else begin
              phase_nxt = PH_FAULTED;
            end
          end else if (phase_r == PH_W_ADDR) begin
            if (rem >= CW'(1)) begin
              phase_nxt     = (rem == CW'(1)) ? PH_W_LAST : PH_W_MIDDLE;
              res.send_data = 1'b1;
              res.tx_byte   = ram_rdata;
              res.gen_stop  = (rem == CW'(1)) && is_last;
              cursor_nxt    = cursor_r + CW'(1);
            end else begin
              phase_nxt = PH_FAULTED;
            end
          end else begin
            phase_nxt = PH_FAULTED;
          end
        end
        OP_BYTE_DONE: begin
          case (phase_r) inside
            PH_R_PRE_FIRST, PH_R_PRE_MIDDLE: begin
              if (rem >= CW'(2)) begin
                ram_we       = 1'b1;
                ram_waddr    = cursor_r[AW-1:0];
                res.rx_valid = 1'b1;
                res.rx_byte  = s1_data_r;
                res.rx_index = 6'(cursor_r);
                cursor_nxt   = cursor_r + CW'(1);
                if (rem == CW'(2)) begin
                  phase_nxt     = PH_R_PRE_LAST;
                  ack_nxt       = 1'b0;
                  res.gen_stop  = is_last;
                  res.gen_start = !is_last;
                end else begin
                  phase_nxt = PH_R_PRE_MIDDLE;
                end
              end else begin
                phase_nxt = PH_FAULTED;
              end
            end
            PH_R_PRE_ONE, PH_R_PRE_LAST: begin
              if (rem == CW'(1)) begin
                ram_we       = 1'b1;
                ram_waddr    = cursor_r[AW-1:0];
                res.rx_valid = 1'b1;
                res.rx_byte  = s1_data_r;
                res.rx_index = 6'(cursor_r);
                cursor_nxt   = cursor_r + CW'(1);
                if (is_last) begin
                  phase_nxt       = PH_STOPPED;
                  ack_nxt         = 1'b1;
                  res.finished    = 1'b1;
                  txn_loaded_nxt  = '0;
                  byte_loaded_nxt = '0;
                end else begin
                  txn_cur_nxt = txn_cur_r + TIW'(1);
                  do_enter    = 1'b1;
                end
              end else begin
                phase_nxt = PH_FAULTED;
              end
            end
            PH_W_MIDDLE: begin
              if (rem >= CW'(1)) begin
                phase_nxt     = (rem == CW'(1)) ? PH_W_LAST : PH_W_MIDDLE;
                res.send_data = 1'b1;
                res.tx_byte   = ram_rdata;
                res.gen_stop  = (rem == CW'(1)) && is_last;
                cursor_nxt    = cursor_r + CW'(1);
              end else begin
                phase_nxt = PH_FAULTED;
              end
            end
            PH_W_LAST: begin
              if (rem == '0) begin
                if (is_last) begin
                  phase_nxt       = PH_STOPPED;
                  ack_nxt         = 1'b1;
                  res.finished    = 1'b1;
                  txn_loaded_nxt  = '0;
                  byte_loaded_nxt = '0;
                end else begin
                  txn_cur_nxt = txn_cur_r + TIW'(1);
                  do_enter    = 1'b1;
                end
              end else begin
                phase_nxt = PH_FAULTED;
              end
            end
            default: begin
              phase_nxt = PH_FAULTED;
            end
          endcase
        end
        default: begin
          phase_nxt = PH_FAULTED;
        end
      endcase

      if (do_enter) begin
        end_sum = SW'(cursor_nxt) + SW'(tt_sel.len);
        if (end_sum > SW'(BYTE_DEPTH)) begin
          phase_nxt = PH_FAULTED;
        end else begin
          end_nxt       = CW'(end_sum);
          res.gen_start = 1'b1;
          phase_nxt     = PH_STARTING;
        end
      end
    end

    if (phase_nxt == PH_FAULTED) begin
      res       = '0;
      res.fault = 1'b1;
    end
    res.ack_enable = ack_nxt;
  end

  i2cseq_ram #(
    .WIDTH (8),
    .DEPTH (BYTE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cursor_nxt[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r        <= 1'b0;
      out_v_r       <= 1'b0;
      phase_r       <= PH_STOPPED;
      txn_loaded_r  <= '0;
      txn_cur_r     <= '0;
      byte_loaded_r <= '0;
      cursor_r      <= '0;
      end_r         <= '0;
      ack_r         <= 1'b1;
    end else begin
      if (in_tvalid && in_tready) begin
        s1_v_r <= 1'b1;
      end else if (adv) begin
        s1_v_r <= 1'b0;
      end
      if (adv) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
      phase_r       <= phase_nxt;
      txn_loaded_r  <= txn_loaded_nxt;
      txn_cur_r     <= txn_cur_nxt;
      byte_loaded_r <= byte_loaded_nxt;
      cursor_r      <= cursor_nxt;
      end_r         <= end_nxt;
      ack_r         <= ack_nxt;
    end

    if (in_tvalid && in_tready) begin
      s1_op_r   <= opcode_t'(in_tuser);
      s1_addr_r <= in_tdata[6:0];
      s1_rd_r   <= in_tdata[7];
      s1_len_r  <= in_tdata[14:8];
      s1_data_r <= in_tdata[22:15];
    end
    if (adv) begin
      res_r <= res;
    end
    if (tt_we) begin
      tt_r[txn_loaded_r[TIW-1:0]] <= '{addr: s1_addr_r, rd: s1_rd_r, len: s1_len_r};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tlast  = res_r.finished;
  assign out_tdata  = {3'b000, res_r.fault, res_r.rx_index, res_r.rx_byte, res_r.rx_valid,
                       res_r.tx_byte, res_r.send_data, res_r.addr_byte, res_r.send_addr,
                       res_r.ack_enable, res_r.gen_stop, res_r.gen_start};

  assign res_cmd = res_r.gen_start || res_r.gen_stop || res_r.send_addr ||
                   res_r.send_data || res_r.rx_valid || res_r.finished;

  `ASSERT_NEXT(a_fault_sticky, phase_r == PH_FAULTED, phase_r == PH_FAULTED)
  `ASSERT_ALWAYS(a_cursor_bound, cursor_r <= end_r && end_r <= CW'(BYTE_DEPTH))
  `ASSERT_ALWAYS(a_txn_bound, txn_loaded_r <= TLW'(MAX_TXNS))
  `ASSERT_ALWAYS(a_fault_quiet, !(out_v_r && res_r.fault) || !res_cmd)

endmodule

/* tb/i2cseq_checker.sv */
`timescale 1ns / 100ps

module i2cseq_checker
  import i2cseq_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,
  input  logic [2:0]          in_tuser,
  input  logic                out_tvalid,
  input  logic                out_tready,
  input  logic [OutDataW-1:0] out_tdata,
  input  logic                out_tlast,
  output int unsigned         errors,
  output int unsigned         pending
);

  typedef enum logic [3:0] {
    SEQ_STOPPED,
    SEQ_FAULTED,
    SEQ_STARTING,
    SEQ_R_ADDR,
    SEQ_R_ONE,
    SEQ_R_FIRST,
    SEQ_R_MIDDLE,
    SEQ_R_LAST,
    SEQ_W_ADDR,
    SEQ_W_MIDDLE,
    SEQ_W_LAST
  } seq_phase_t;

  seq_phase_t phase;
  logic [6:0] tbl_addr [MaxTxnsDefault];
  logic       tbl_rd   [MaxTxnsDefault];
  logic [6:0] tbl_len  [MaxTxnsDefault];
  logic [2:0] txn_loaded;
  logic [1:0] txn_cur;
  logic [7:0] store [ByteDepthDefault];
  logic [6:0] byte_loaded;
  logic [6:0] cursor;
  logic [6:0] end_pos;
  logic       ack;
  result_t    expected_q [$];

  function automatic logic on_last_txn();
    return ({1'b0, txn_cur} + 3'd1) >= txn_loaded;
  endfunction

  function automatic void open_txn(inout result_t r);
    logic [6:0] len;
    if ({1'b0, txn_cur} >= txn_loaded) begin
      phase = SEQ_FAULTED;
      return;
    end
    len = tbl_len[txn_cur];
    if (int'(cursor) + int'(len) > ByteDepthDefault) begin
      phase = SEQ_FAULTED;
      return;
    end
    end_pos = cursor + len;
    r.gen_start = 1'b1;
    phase = SEQ_STARTING;
  endfunction

  function automatic void capture(inout result_t r, input logic [7:0] d);
    if (cursor < 7'(ByteDepthDefault)) store[cursor[5:0]] = d;
    r.rx_valid = 1'b1;
    r.rx_byte  = d;
    r.rx_index = cursor[5:0];
    cursor++;
  endfunction

  function automatic void send_next(inout result_t r);
    r.send_data = 1'b1;
    r.tx_byte   = (cursor < 7'(ByteDepthDefault)) ? store[cursor[5:0]] : 8'h00;
    cursor++;
  endfunction

  function automatic void send_last(inout result_t r);
    phase = SEQ_W_LAST;
    send_next(r);
    if (on_last_txn()) r.gen_stop = 1'b1;
  endfunction

  // The final transaction ends the transfer; otherwise a repeated start follows.
  function automatic void close_txn(inout result_t r);
    if (on_last_txn()) begin
      phase       = SEQ_STOPPED;
      ack         = 1'b1;
      r.finished  = 1'b1;
      txn_loaded  = '0;
      byte_loaded = '0;
    end else begin
      txn_cur++;
      open_txn(r);
    end
  endfunction

  function automatic void early_end(inout result_t r);
    ack = 1'b0;
    if (on_last_txn()) r.gen_stop = 1'b1;
    else r.gen_start = 1'b1;
  endfunction

  function automatic void read_advance(inout result_t r, input logic [6:0] rem);
    if (rem == 7'd2) begin
      phase = SEQ_R_LAST;
      early_end(r);
    end else if (rem > 7'd2) begin
      phase = SEQ_R_MIDDLE;
    end else begin
      phase = SEQ_FAULTED;
    end
  endfunction

  function automatic result_t predict_result(logic [2:0] op, logic [6:0] addr, logic rd,
                                             logic [6:0] cnt, logic [7:0] d);
    result_t    r;
    logic [6:0] rem;
    r   = '0;
    rem = (end_pos > cursor) ? end_pos - cursor : 7'd0;
    if (phase != SEQ_FAULTED) begin
      case (op)
        OP_LOAD_TXN: begin
          if (phase == SEQ_STOPPED && txn_loaded < 3'(MaxTxnsDefault)) begin
            tbl_addr[txn_loaded[1:0]] = addr;
            tbl_rd[txn_loaded[1:0]]   = rd;
            tbl_len[txn_loaded[1:0]]  = cnt;
            txn_loaded++;
          end
        end
        OP_LOAD_BYTE: begin
          if (phase == SEQ_STOPPED && byte_loaded < 7'(ByteDepthDefault)) begin
            store[byte_loaded[5:0]] = d;
            byte_loaded++;
          end
        end
        OP_START: begin
          if (phase == SEQ_STOPPED && txn_loaded != '0) begin
            txn_cur = '0;
            cursor  = '0;
            open_txn(r);
          end else begin
            phase = SEQ_FAULTED;
          end
        end
        OP_START_SENT: begin
          if (phase == SEQ_STARTING) begin
            r.send_addr = 1'b1;
            r.addr_byte = {tbl_addr[txn_cur], tbl_rd[txn_cur]};
            phase = tbl_rd[txn_cur] ? SEQ_R_ADDR : SEQ_W_ADDR;
          end else begin
            phase = SEQ_FAULTED;
          end
        end
        OP_ADDR_ACKED: begin
          if (phase == SEQ_R_ADDR) begin
            if (rem == 7'd1) begin
              phase = SEQ_R_ONE;
              early_end(r);
            end else if (rem >= 7'd2) begin
              phase = SEQ_R_FIRST;
              ack   = 1'b1;
            end else begin
              phase = SEQ_FAULTED;
            end
          end else if (phase == SEQ_W_ADDR) begin
            if (rem == 7'd1) begin
              send_last(r);
            end else if (rem >= 7'd2) begin
              phase = SEQ_W_MIDDLE;
              send_next(r);
            end else begin
              phase = SEQ_FAULTED;
            end
          end else begin
            phase = SEQ_FAULTED;
          end
        end
        OP_BYTE_DONE: begin
          if (phase == SEQ_R_FIRST || phase == SEQ_R_MIDDLE) begin
            read_advance(r, rem);
            if (phase == SEQ_R_MIDDLE || phase == SEQ_R_LAST) capture(r, d);
          end else if (phase == SEQ_R_ONE || phase == SEQ_R_LAST) begin
            if (rem == 7'd1) begin
              capture(r, d);
              close_txn(r);
            end else begin
              phase = SEQ_FAULTED;
            end
          end else if (phase == SEQ_W_MIDDLE) begin
            if (rem == 7'd1) send_last(r);
            else if (rem >= 7'd2) send_next(r);
            else phase = SEQ_FAULTED;
          end else if (phase == SEQ_W_LAST) begin
            if (rem == 7'd0) close_txn(r);
            else phase = SEQ_FAULTED;
          end else begin
            phase = SEQ_FAULTED;
          end
        end
        default: phase = SEQ_FAULTED;
      endcase
    end
    if (phase == SEQ_FAULTED) begin
      r       = '0;
      r.fault = 1'b1;
    end
    r.ack_enable = ack;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    $display("%0t: %s", $time, msg);
  endtask

  task automatic compare_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  task automatic compare_result(result_t got, result_t want);
    compare_field("gen_start", 8'(got.gen_start), 8'(want.gen_start));
    compare_field("gen_stop", 8'(got.gen_stop), 8'(want.gen_stop));
    compare_field("ack_enable", 8'(got.ack_enable), 8'(want.ack_enable));
    compare_field("send_addr", 8'(got.send_addr), 8'(want.send_addr));
    compare_field("addr_byte", got.addr_byte, want.addr_byte);
    compare_field("send_data", 8'(got.send_data), 8'(want.send_data));
    compare_field("tx_byte", got.tx_byte, want.tx_byte);
    compare_field("rx_valid", 8'(got.rx_valid), 8'(want.rx_valid));
    compare_field("rx_byte", got.rx_byte, want.rx_byte);
    compare_field("rx_index", 8'(got.rx_index), 8'(want.rx_index));
    compare_field("finished", 8'(got.finished), 8'(want.finished));
    compare_field("fault", 8'(got.fault), 8'(want.fault));
  endtask

  always @(posedge clk) begin : watch
    result_t got;
    if (!rst_n) begin
      phase       = SEQ_STOPPED;
      txn_loaded  = '0;
      txn_cur     = '0;
      byte_loaded = '0;
      cursor      = '0;
      end_pos     = '0;
      ack         = 1'b1;
      expected_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = {out_tdata[36], out_tlast, out_tdata[35:0]};
        if (expected_q.size() == 0) report_mismatch("result arrived with no request outstanding");
        else compare_result(got, expected_q.pop_front());
      end
      if (in_tvalid && in_tready)
        expected_q.push_back(predict_result(in_tuser, in_tdata[6:0], in_tdata[7],
                                            in_tdata[14:8], in_tdata[22:15]));
    end
    pending = expected_q.size();
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import i2cseq_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned ItemTarget = 1850;
  localparam logic [2:0]  OpUndefined = 3'd7;

  typedef enum logic [2:0] {
    FK_ERROR,
    FK_UNDEFINED_OP,
    FK_EMPTY_START,
    FK_BUSY_START,
    FK_ZERO_LEN,
    FK_OVERSIZE,
    FK_STRAY_EVENT,
    FK_ERROR_MID
  } fault_kind_t;

  logic                clk;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata   = '0;
  logic [2:0]          in_tuser   = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                out_tlast;
  int unsigned         errors;
  int unsigned         pending;

  int unsigned cycles     = 0;
  int unsigned sent       = 0;
  int unsigned stall_left = 0;
  int unsigned mode_left  = 0;
  logic        calm       = 1'b0;
  logic        idle_on    = 1'b1;

  logic [6:0] plan_addr [6];
  logic       plan_rd   [6];
  logic [6:0] plan_len  [6];
  int unsigned plan_n;
  int unsigned plan_extra;

  i2c_master_transaction_sequencer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  i2cseq_checker watcher (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .errors     (errors),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // The receiver alternates between calm stretches and stretches of random stalls.
  always @(negedge clk) begin
    if (mode_left == 0) begin
      calm      = ($urandom_range(3) == 0);
      mode_left = $urandom_range(50, 400);
    end else begin
      mode_left--;
    end
    if (stall_left == 0 && !calm && $urandom_range(2) == 0) stall_left = pick_gap();
    if (stall_left != 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic issue(logic [2:0] op, logic [6:0] addr, logic rd, logic [6:0] cnt,
                       logic [7:0] d);
    int unsigned gap;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {1'b0, d, cnt, rd, addr};
    do @(posedge clk); while (!in_tready);
    sent++;
    gap = idle_on ? pick_gap() : 0;
    if (gap != 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic issue_event(logic [2:0] op);
    issue(op, 7'($urandom), 1'($urandom), 7'($urandom), 8'($urandom));
  endtask

  // Loads issued while the block is busy must be ignored.
  task automatic bus_event(logic [2:0] op);
    if ($urandom_range(11) == 0)
      issue_event($urandom_range(1) ? OP_LOAD_TXN : OP_LOAD_BYTE);
    issue_event(op);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Every store position that a write transaction sends from is loaded first.
  task automatic run_transfer();
    int unsigned used, total, txn_left, byte_left, i, k;
    used  = (plan_n > MaxTxnsDefault) ? MaxTxnsDefault : plan_n;
    total = 0;
    for (i = 0; i < used; i++) total += 32'(plan_len[i]);
    txn_left  = plan_n;
    byte_left = total + plan_extra;
    i = 0;
    while (txn_left + byte_left != 0) begin
      if (byte_left == 0 ||
          (txn_left != 0 && $urandom_range(byte_left + txn_left - 1) < txn_left)) begin
        issue(OP_LOAD_TXN, plan_addr[i], plan_rd[i], plan_len[i], 8'($urandom));
        i++;
        txn_left--;
      end else begin
        issue_event(OP_LOAD_BYTE);
        byte_left--;
      end
    end
    issue_event(OP_START);
    for (i = 0; i < used; i++) begin
      bus_event(OP_START_SENT);
      bus_event(OP_ADDR_ACKED);
      for (k = 0; k < 32'(plan_len[i]); k++) bus_event(OP_BYTE_DONE);
    end
  endtask

  initial begin
    int unsigned used, budget, i;
    fault_kind_t kind;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    plan_n = 5;
    plan_extra = 0;
    plan_addr = '{7'd127, 7'd0, 7'd85, 7'd42, 7'd7, 7'd0};
    plan_rd   = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    plan_len  = '{7'd2, 7'd1, 7'd1, 7'd2, 7'd3, 7'd0};
    run_transfer();
    drain();

    plan_n = 1;
    plan_extra = 4;
    plan_addr[0] = 7'($urandom);
    plan_rd[0]   = 1'($urandom);
    plan_len[0]  = 7'd64;
    run_transfer();

    while (sent < ItemTarget) begin
      idle_on = ($urandom_range(3) != 0);
      plan_n  = ($urandom_range(9) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
      used    = (plan_n > MaxTxnsDefault) ? MaxTxnsDefault : plan_n;
      budget  = ByteDepthDefault;
      for (i = 0; i < 6; i++) begin
        plan_addr[i] = 7'($urandom);
        plan_rd[i]   = 1'($urandom);
        plan_len[i]  = 7'($urandom);
      end
      if ($urandom_range(14) == 0) begin
        for (i = 0; i < used; i++) begin
          plan_len[i] = 7'((i == used - 1) ? budget
                                           : $urandom_range(1, budget - (used - 1 - i)));
          budget -= 32'(plan_len[i]);
        end
      end else begin
        for (i = 0; i < used; i++) plan_len[i] = 7'($urandom_range(1, 5));
      end
      plan_extra = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
      run_transfer();
      if ($urandom_range(9) == 0) drain();
    end

    // The fault state is sticky, so a single fault scenario closes the run.
    idle_on = 1'b1;
    kind = fault_kind_t'($urandom_range(7));
    case (kind)
      FK_ERROR: issue_event(OP_ERROR);
      FK_UNDEFINED_OP: issue_event(OpUndefined);
      FK_EMPTY_START: issue_event(OP_START);
      FK_BUSY_START: begin
        issue(OP_LOAD_TXN, 7'($urandom), 1'b0, 7'd2, 8'($urandom));
        issue_event(OP_START);
        issue_event(OP_START_SENT);
        issue_event(OP_START);
      end
      FK_ZERO_LEN: begin
        issue(OP_LOAD_TXN, 7'($urandom), 1'($urandom), 7'd0, 8'($urandom));
        issue_event(OP_START);
        issue_event(OP_START_SENT);
        issue_event(OP_ADDR_ACKED);
      end
      FK_OVERSIZE: begin
        issue(OP_LOAD_TXN, 7'($urandom), 1'($urandom), 7'($urandom_range(65, 127)),
              8'($urandom));
        issue_event(OP_START);
      end
      FK_STRAY_EVENT: issue_event(3'($urandom_range(OP_START_SENT, OP_BYTE_DONE)));
      default: begin
        issue(OP_LOAD_TXN, 7'($urandom), 1'b1, 7'd3, 8'($urandom));
        issue_event(OP_START);
        issue_event(OP_START_SENT);
        issue_event(OP_ADDR_ACKED);
        issue_event(OP_ERROR);
      end
    endcase
    repeat (12) issue_event(3'($urandom_range(7)));

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
